// ===== hw/rtl/pur_pkg.sv =====
// Shared types and constants of the polyline uniform resampler.
package pur_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int LEN_W      = 33;
    localparam int CD_W       = 34;
    localparam int SPC_W      = 31;
    localparam int TOL_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 66;
    localparam int SQ_REM_W   = 35;
    localparam int CNT_W      = 6;
    localparam int PTS_W      = 6;

    typedef enum logic [0:0] {
        REG_SPACING   = 1'b0,
        REG_TOLERANCE = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_LEN,
        ST_DIVK,
        ST_CNT,
        ST_PNT,
        ST_RDIV,
        ST_MULX,
        ST_MULY,
        ST_EMIT,
        ST_END
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      eop;
        logic                      first;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef struct packed {
        logic [SPC_W-1:0] spacing;
        logic [TOL_W-1:0] tolerance;
    } t_cfg;

endpackage

// ===== hw/rtl/pur_in_if.sv =====
// Vertex input channel.
interface pur_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [pur_pkg::COORD_W-1:0] point_x;
    logic signed [pur_pkg::COORD_W-1:0] point_y;
    logic                             end_of_path;

    modport source (output valid, output point_x, output point_y, output end_of_path,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input end_of_path,
                  output ready);
endinterface

// ===== hw/rtl/pur_out_if.sv =====
// Resampled point output channel.
interface pur_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pur_pkg::COORD_W-1:0] out_x;
    logic signed [pur_pkg::COORD_W-1:0] out_y;
    logic                             point_valid;
    logic                             run_last;
    logic                             path_done;
    logic                             overflow;

    modport source (output valid, output out_x, output out_y, output point_valid,
                    output run_last, output path_done, output overflow, input ready);
    modport sink (input valid, input out_x, input out_y, input point_valid,
                  input run_last, input path_done, input overflow, output ready);
endinterface

// ===== hw/rtl/pur_cfg_if.sv =====
// Configuration write channel.
interface pur_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [0:0]                          index;
    logic [pur_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pur_front.sv =====
// Front end: accepts vertices, marks the first vertex of a path, queues them.
module pur_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pur_in_if.sink         i_in,
    output pur_pkg::t_q2b  o_head,
    input  logic           i_pop
);
    import pur_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       r_inside;
    logic       push;

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            r_inside <= 1'b0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= '{x: i_in.point_x, y: i_in.point_y,
                                 eop: i_in.end_of_path, first: !r_inside};
                r_wp        <= !r_wp;
                r_inside    <= !i_in.end_of_path;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/pur_back.sv =====
// Back end: segment length, point count, interpolation and result register.
module pur_back #(
    parameter int MAX_POINTS_PER_SEGMENT = 63,
    parameter int COORD_FRAC_BITS        = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pur_pkg::t_q2b  i_head,
    output logic           o_pop,
    input  pur_pkg::t_cfg  i_cfg,
    pur_out_if.source      o_out
);
    import pur_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int RW = F + 1;
    localparam int NW = LEN_W + F + 1;
    localparam logic [RW-1:0]    ONE  = RW'(1) << F;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (F - 1);
    localparam logic [PTS_W-1:0] MAXP = PTS_W'(MAX_POINTS_PER_SEGMENT);

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_x, r_y, r_prev_x, r_prev_y, r_lex, r_ley, r_px, r_py;
    logic                      r_eop, r_ovf;
    logic                      r_sx, r_sy;
    logic [DIFF_W-1:0]         r_adx, r_ady;
    logic [PROD_W-1:0]         r_sum;
    logic [SQ_REM_W-1:0]       r_sqrem;
    logic [LEN_W-1:0]          r_root;
    logic [SPC_W-1:0]          r_carry;
    logic [CD_W-1:0]           r_cd, r_dvd, r_quo, r_exc;
    logic [SPC_W-1:0]          r_drem;
    logic [LEN_W-1:0]          r_rrem;
    logic [RW-1:0]             r_nlow, r_rq;
    logic [PTS_W-1:0]          r_left;
    logic [CNT_W-1:0]          r_cnt;

    logic                      r_ov;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic                      r_opv, r_orl, r_opd, r_oovf;

    logic                      can_ld, ld, fin;
    logic [SPC_W-1:0]          spc;
    logic [DIFF_W-1:0]         dx, dy, ex, ey, aex, aey;
    logic [DIFF_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]         prod, rnd;
    logic [COORD_W-1:0]        mag;
    logic [SQ_REM_W+1:0]       sq_t, sq_trial;
    logic                      sq_ge;
    logic [SPC_W:0]            dv_t;
    logic                      dv_ge;
    logic [LEN_W:0]            rd_t;
    logic                      rd_ge;
    logic [LEN_W-1:0]          num;
    logic [NW-1:0]             nbig;
    logic                      kovf;
    logic [PTS_W-1:0]          kpts;
    logic [RW-1:0]             ratio;
    logic                      close;

    assign spc    = (i_cfg.spacing == '0) ? SPC_W'(1) : i_cfg.spacing;
    assign can_ld = !r_ov || o_out.ready;

    assign dx = {i_head.item.x[COORD_W-1], i_head.item.x} - {r_prev_x[COORD_W-1], r_prev_x};
    assign dy = {i_head.item.y[COORD_W-1], i_head.item.y} - {r_prev_y[COORD_W-1], r_prev_y};
    assign ex = {r_x[COORD_W-1], r_x} - {r_lex[COORD_W-1], r_lex};
    assign ey = {r_y[COORD_W-1], r_y} - {r_ley[COORD_W-1], r_ley};
    assign aex = ex[DIFF_W-1] ? -ex : ex;
    assign aey = ey[DIFF_W-1] ? -ey : ey;
    assign close = (aex < DIFF_W'(i_cfg.tolerance)) && (aey < DIFF_W'(i_cfg.tolerance));

    assign ratio = (r_rq > ONE) ? ONE : r_rq;

    always_comb begin
        case (r_state)
            ST_SQX:  begin mul_a = r_adx; mul_b = r_adx; end
            ST_SQY:  begin mul_a = r_ady; mul_b = r_ady; end
            ST_MULX: begin mul_a = r_adx; mul_b = DIFF_W'(ratio); end
            ST_MULY: begin mul_a = r_ady; mul_b = DIFF_W'(ratio); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;
    assign rnd  = prod + HALF;
    assign mag  = rnd[F+COORD_W-1:F];

    assign sq_t     = {r_sqrem, r_sum[PROD_W-1:PROD_W-2]};
    assign sq_trial = (SQ_REM_W+2)'({r_root, 2'b01});
    assign sq_ge    = (sq_t >= sq_trial);

    assign dv_t  = {r_drem, r_dvd[CD_W-1]};
    assign dv_ge = (dv_t >= {1'b0, spc});

    assign rd_t  = {r_rrem, r_nlow[RW-1]};
    assign rd_ge = (rd_t >= {1'b0, r_root});

    assign num  = ({1'b0, r_root} > r_exc) ? r_root - r_exc[LEN_W-1:0] : '0;
    assign nbig = {1'b0, num, {F{1'b0}}} + NW'(r_root >> 1);

    assign kovf = (r_quo > CD_W'(MAXP));
    assign kpts = kovf ? MAXP : r_quo[PTS_W-1:0];

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        ld      = 1'b0;
        fin     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = i_head.item.first ? ST_FIRST : ST_SQX;
                end
            end
            ST_FIRST: begin
                if (can_ld) begin
                    ld      = 1'b1;
                    fin     = 1'b1;
                    n_state = r_eop ? ST_END : ST_IDLE;
                end
            end
            ST_SQX: n_state = ST_SQY;
            ST_SQY: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: n_state = ST_DIVK;
            ST_DIVK: begin
                if (r_cnt == '0) begin
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                if (kpts == '0) begin
                    fin     = 1'b1;
                    n_state = r_eop ? ST_END : ST_IDLE;
                end else begin
                    n_state = ST_PNT;
                end
            end
            ST_PNT: n_state = (r_root == '0) ? ST_MULX : ST_RDIV;
            ST_RDIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_MULX;
                end
            end
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_EMIT;
            ST_EMIT: begin
                if (can_ld) begin
                    ld = 1'b1;
                    if (r_left == PTS_W'(1)) begin
                        fin     = 1'b1;
                        n_state = r_eop ? ST_END : ST_IDLE;
                    end else begin
                        n_state = ST_PNT;
                    end
                end
            end
            ST_END: begin
                if (can_ld) begin
                    ld      = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_lex    <= '0;
            r_ley    <= '0;
            r_carry  <= '0;
        end else begin
            if (ld) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (fin) begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
            end
            case (r_state)
                ST_IDLE: begin
                    r_x   <= i_head.item.x;
                    r_y   <= i_head.item.y;
                    r_eop <= i_head.item.eop;
                    r_ovf <= 1'b0;
                    r_sx  <= dx[DIFF_W-1];
                    r_sy  <= dy[DIFF_W-1];
                    r_adx <= dx[DIFF_W-1] ? -dx : dx;
                    r_ady <= dy[DIFF_W-1] ? -dy : dy;
                end
                ST_FIRST: begin
                    if (ld) begin
                        r_ox    <= r_x;
                        r_oy    <= r_y;
                        r_opv   <= 1'b1;
                        r_orl   <= !r_eop;
                        r_opd   <= 1'b0;
                        r_oovf  <= 1'b0;
                        r_lex   <= r_x;
                        r_ley   <= r_y;
                        r_carry <= '0;
                    end
                end
                ST_SQX: r_sum <= prod;
                ST_SQY: begin
                    r_sum   <= r_sum + prod;
                    r_sqrem <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_W'(32);
                end
                ST_SQRT: begin
                    r_sum   <= r_sum << 2;
                    r_sqrem <= sq_ge ? SQ_REM_W'(sq_t - sq_trial) : SQ_REM_W'(sq_t);
                    r_root  <= {r_root[LEN_W-2:0], sq_ge};
                    r_cnt   <= r_cnt - CNT_W'(1);
                end
                ST_LEN: begin
                    r_cd   <= CD_W'(r_carry) + CD_W'(r_root);
                    r_dvd  <= CD_W'(r_carry) + CD_W'(r_root);
                    r_drem <= '0;
                    r_quo  <= '0;
                    r_cnt  <= CNT_W'(CD_W - 1);
                end
                ST_DIVK: begin
                    r_dvd  <= r_dvd << 1;
                    r_drem <= dv_ge ? SPC_W'(dv_t - {1'b0, spc}) : SPC_W'(dv_t);
                    r_quo  <= {r_quo[CD_W-2:0], dv_ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
                ST_CNT: begin
                    r_ovf   <= kovf;
                    r_left  <= kpts;
                    r_exc   <= r_cd - CD_W'(spc);
                    r_carry <= r_drem;
                end
                ST_PNT: begin
                    r_rq   <= ONE;
                    r_rrem <= nbig[NW-1:RW];
                    r_nlow <= nbig[RW-1:0];
                    r_cnt  <= CNT_W'(F);
                end
                ST_RDIV: begin
                    r_rrem <= rd_ge ? LEN_W'(rd_t - {1'b0, r_root}) : LEN_W'(rd_t);
                    r_nlow <= r_nlow << 1;
                    r_rq   <= {r_rq[RW-2:0], rd_ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
                ST_MULX: r_px <= r_sx ? r_prev_x - $signed(mag) : r_prev_x + $signed(mag);
                ST_MULY: r_py <= r_sy ? r_prev_y - $signed(mag) : r_prev_y + $signed(mag);
                ST_EMIT: begin
                    if (ld) begin
                        r_ox   <= r_px;
                        r_oy   <= r_py;
                        r_opv  <= 1'b1;
                        r_orl  <= !r_eop && (r_left == PTS_W'(1));
                        r_opd  <= 1'b0;
                        r_oovf <= r_ovf;
                        r_lex  <= r_px;
                        r_ley  <= r_py;
                        r_exc  <= r_exc - CD_W'(spc);
                        r_left <= r_left - PTS_W'(1);
                    end
                end
                ST_END: begin
                    if (ld) begin
                        r_ox    <= close ? '0 : r_x;
                        r_oy    <= close ? '0 : r_y;
                        r_opv   <= !close;
                        r_orl   <= 1'b1;
                        r_opd   <= 1'b1;
                        r_oovf  <= r_ovf;
                        r_carry <= '0;
                        if (!close) begin
                            r_lex <= r_x;
                            r_ley <= r_y;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_x       = r_ox;
    assign o_out.out_y       = r_oy;
    assign o_out.point_valid = r_opv;
    assign o_out.run_last    = r_orl;
    assign o_out.path_done   = r_opd;
    assign o_out.overflow    = r_oovf;

`ifndef SYNTH
    a_marker_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.point_valid |->
            o_out.path_done && o_out.out_x == 0 && o_out.out_y == 0)
        else $error("closing marker malformed");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.path_done |-> o_out.run_last)
        else $error("path_done without run_last");
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_left != '0 && r_left <= MAXP)
        else $error("point count out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != ST_IDLE)
        else $error("popped vertex not taken up");
`endif

endmodule

// ===== hw/rtl/polyline_uniform_resampler.sv =====
// Polyline uniform resampler top level: configuration registers and front/back ends.
// Vertices (signed Q16.16) enter through a two-entry queue, so the input
// can take up to two vertices while the back end works. The first vertex of a
// path is passed straight out; a later vertex goes through the squares, a
// 33-step square root and a 34-step division by the spacing, plus per emitted
// point a ratio division and two shared multiplies, plus an endpoint step at
// the end of a path. The result register lets the back end finish a result
// while the previous one waits. Spacing and tolerance must be written only
// while the block is idle; the block itself does not enforce this.
module polyline_uniform_resampler #(
    parameter int MAX_POINTS_PER_SEGMENT = 63,
    parameter int COORD_FRAC_BITS        = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pur_in_if.sink    i_in,
    pur_out_if.source o_out,
    pur_cfg_if.sink   i_cfg
);
    import pur_pkg::*;

    t_cfg r_cfg;
    t_q2b head;
    logic pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing   <= SPC_W'(65536);
            r_cfg.tolerance <= TOL_W'(1);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SPACING:   r_cfg.spacing   <= i_cfg.data[SPC_W-1:0];
                REG_TOLERANCE: r_cfg.tolerance <= i_cfg.data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pur_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (head),
        .i_pop   (pop)
    );

    pur_back #(
        .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT),
        .COORD_FRAC_BITS        (COORD_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule
